>>> rtl/ptre_pkg.sv
package ptre_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [13:0] ADDR_MODE      = 14'h0000;
    localparam logic [13:0] ADDR_EXT_MODE  = 14'h0002;
    localparam logic [13:0] ADDR_EVENT     = 14'h0003;
    localparam logic [13:0] ADDR_REFERENCE = 14'h0004;
    localparam logic [13:0] ADDR_CAPTURE   = 14'h0008;
    localparam logic [13:0] ADDR_COUNTER   = 14'h000c;

    localparam int RUN_BIT     = 0;
    localparam int EVT_REF_BIT = 1;

    localparam logic [39:0] MIN_PERIOD_CLOCKS = 40'd125;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] addr;
        logic [31:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq;
    } out_item_t;

endpackage

>>> rtl/ptre_in_reg.sv
module ptre_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ptre_pkg::in_item_t in_data,
    input  logic               take,
    output logic               item_valid,
    output ptre_pkg::in_item_t item
);
    import ptre_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // the slot frees up in the same cycle its item moves on
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> rtl/ptre_core.sv
module ptre_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                exec,
    input  ptre_pkg::in_item_t  item,
    output ptre_pkg::out_item_t result
);
    import ptre_pkg::*;

    logic [15:0] mode_reg,      mode_next;
    logic [7:0]  ext_mode_reg,  ext_mode_next;
    logic [7:0]  event_reg,     event_next;
    logic [31:0] reference_reg, reference_next;
    logic [31:0] capture_reg,   capture_next;
    logic [31:0] count_reg,     count_next;
    logic [7:0]  phase_reg,     phase_next;
    logic [39:0] countdown_reg, countdown_next;
    logic [39:0] period_reg,    period_next;
    logic        active_reg,    active_next;
    logic        irq_reg,       irq_next;

    logic        sel_mode;
    logic [31:0] mul_a;
    logic [8:0]  mul_b;
    logic [39:0] mul_full;
    logic [39:0] arm_period;
    logic        arm_zero;
    logic [31:0] rd;

    // one shared 32x9 multiplier: reference times divisor for any arming write
    assign sel_mode   = (item.addr == ADDR_MODE);
    assign mul_a      = sel_mode ? reference_reg : item.write_data;
    assign mul_b      = sel_mode ? ({1'b0, item.write_data[15:8]} + 9'd1)
                                 : ({1'b0, mode_reg[15:8]} + 9'd1);
    assign mul_full   = {8'd0, mul_a} * {31'd0, mul_b};
    assign arm_period = (mul_full < MIN_PERIOD_CLOCKS) ? MIN_PERIOD_CLOCKS
                                                       : mul_full;
    assign arm_zero   = (mul_a == 32'd0);

    always_comb
    begin
        unique case (item.addr)
            ADDR_MODE:      rd = {16'd0, mode_reg};
            ADDR_EXT_MODE:  rd = {24'd0, ext_mode_reg};
            ADDR_EVENT:     rd = {24'd0, event_reg};
            ADDR_REFERENCE: rd = reference_reg;
            ADDR_CAPTURE:   rd = capture_reg;
            ADDR_COUNTER:   rd = count_reg;
            default:        rd = 32'd0;
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        ext_mode_next  = ext_mode_reg;
        event_next     = event_reg;
        reference_next = reference_reg;
        capture_next   = capture_reg;
        count_next     = count_reg;
        phase_next     = phase_reg;
        countdown_next = countdown_reg;
        period_next    = period_reg;
        active_next    = active_reg;
        irq_next       = irq_reg;
        result.read_data = 32'd0;

        if (exec)
        begin
            unique case (item.action)
                ACT_TICK:
                begin
                    // phase never exceeds divisor-1, so equality marks the wrap
                    if (phase_reg == mode_reg[15:8])
                    begin
                        phase_next = 8'd0;
                        count_next = count_reg + 32'd1;
                    end
                    else
                    begin
                        phase_next = phase_reg + 8'd1;
                    end
                    if (active_reg)
                    begin
                        if (countdown_reg == 40'd1)
                        begin
                            // run bit is always set while active: re-arm
                            event_next[EVT_REF_BIT] = 1'b1;
                            irq_next                = 1'b1;
                            countdown_next          = period_reg;
                        end
                        else
                        begin
                            countdown_next = countdown_reg - 40'd1;
                        end
                    end
                end
                ACT_READ:
                begin
                    result.read_data = rd;
                end
                ACT_WRITE:
                begin
                    unique case (item.addr)
                        ADDR_MODE:
                        begin
                            phase_next = 8'd0;
                            mode_next  = item.write_data[15:0];
                            if (!item.write_data[RUN_BIT])
                            begin
                                active_next    = 1'b0;
                                countdown_next = 40'd0;
                                irq_next       = 1'b0;
                            end
                            else if (arm_zero)
                            begin
                                active_next    = 1'b0;
                                countdown_next = 40'd0;
                            end
                            else
                            begin
                                active_next    = 1'b1;
                                countdown_next = arm_period;
                                period_next    = arm_period;
                            end
                        end
                        ADDR_EXT_MODE:
                        begin
                            ext_mode_next = item.write_data[7:0];
                        end
                        ADDR_EVENT:
                        begin
                            event_next = event_reg & ~item.write_data[7:0];
                            if (item.write_data[EVT_REF_BIT])
                            begin
                                irq_next = 1'b0;
                            end
                        end
                        ADDR_REFERENCE:
                        begin
                            reference_next = item.write_data;
                            if (mode_reg[RUN_BIT])
                            begin
                                if (arm_zero)
                                begin
                                    active_next    = 1'b0;
                                    countdown_next = 40'd0;
                                end
                                else
                                begin
                                    active_next    = 1'b1;
                                    countdown_next = arm_period;
                                    period_next    = arm_period;
                                end
                            end
                        end
                        ADDR_CAPTURE:
                        begin
                            capture_next = item.write_data;
                        end
                        ADDR_COUNTER:
                        begin
                            count_next = item.write_data;
                            phase_next = 8'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
        result.irq = irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 16'd0;
            ext_mode_reg  <= 8'd0;
            event_reg     <= 8'd0;
            reference_reg <= 32'd0;
            capture_reg   <= 32'd0;
            count_reg     <= 32'd0;
            phase_reg     <= 8'd0;
            countdown_reg <= 40'd0;
            period_reg    <= 40'd0;
            active_reg    <= 1'b0;
            irq_reg       <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            ext_mode_reg  <= ext_mode_next;
            event_reg     <= event_next;
            reference_reg <= reference_next;
            capture_reg   <= capture_next;
            count_reg     <= count_next;
            phase_reg     <= phase_next;
            countdown_reg <= countdown_next;
            period_reg    <= period_next;
            active_reg    <= active_next;
            irq_reg       <= irq_next;
        end
    end

endmodule

>>> rtl/ptre_out_reg.sv
module ptre_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ptre_pkg::out_item_t result,
    output logic                can_load,
    output logic                out_valid,
    input  logic                out_ready,
    output ptre_pkg::out_item_t out_data
);
    import ptre_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/prescaled_timer_reference_event_unit.sv
// Prescaled timer with reference-compare event, driven by one item per cycle (tick, register
// read or register write). Items are taken at a sustained rate of one per clock while results
// are accepted; each result goes from the input register through one pass of the register
// update logic and its 32x9 reference-times-divisor multiplier into the output register,
// where it is held until out_ready accepts it. The input side stalls only
// while a result sits unaccepted in the output register. Register map by byte offset:
// 0 mode, 2 extmode, 3 event (write-one-to-clear), 4 reference, 8 capture, 12 counter;
// other offsets read zero and ignore writes.
module prescaled_timer_reference_event_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ptre_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ptre_pkg::out_item_t out_data
);
    import ptre_pkg::*;

    logic      item_valid;
    in_item_t  item;
    logic      can_load;
    logic      exec;
    out_item_t result;

    assign exec = item_valid && can_load;

    ptre_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .take       (exec),
        .item_valid (item_valid),
        .item       (item)
    );

    ptre_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .item   (item),
        .result (result)
    );

    ptre_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (exec),
        .result    (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> rtl/ptre_checker.sv
module ptre_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input ptre_pkg::in_item_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input ptre_pkg::out_item_t out_data
);
    import ptre_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // stalled input transfer holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input changed or dropped while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    // input back-pressure comes only from a stalled output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output back-pressure");

    // at most two items in flight: input register and output register
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("more items in flight than storage");

    // no result without a pending item
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result with no item in flight");

endmodule

bind prescaled_timer_reference_event_unit ptre_checker u_ptre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
